// ===== hw/rtl/dnc_pkg.sv =====
// Shared types and constants for the decimal normalize-and-compare block.
// No dependencies; used by every module in hw/rtl.
`default_nettype none
package dnc_pkg;

	localparam int MANT_W = 64;
	localparam int EXP_IN_W = 32;
	localparam int EXP_W = EXP_IN_W + 1;
	localparam logic [MANT_W-1:0] NORM_FLOOR = 64'd1000000000000000000;

	typedef struct packed {
		logic signed [MANT_W-1:0]   a_mantissa;
		logic signed [EXP_IN_W-1:0] a_exponent;
		logic signed [MANT_W-1:0]   b_mantissa;
		logic signed [EXP_IN_W-1:0] b_exponent;
	} in_t;

	typedef struct packed {
		logic is_equal;
		logic is_less;
	} out_t;

	typedef struct packed {
		logic                    neg;
		logic                    zero;
		logic [MANT_W-1:0]       mag;
		logic signed [EXP_W-1:0] exp;
	} norm_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCALE
	} state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/dnc_lane.sv =====
// One normalizing lane: sign/magnitude split, then one multiply-by-ten per cycle
// until the magnitude reaches 10^18 or is zero. Depends on dnc_pkg.
`default_nettype none
module dnc_lane (
	input  wire logic                                clk,
	input  wire logic                                load,
	input  wire logic signed [dnc_pkg::MANT_W-1:0]   mantissa,
	input  wire logic signed [dnc_pkg::EXP_IN_W-1:0] exponent,
	output dnc_pkg::norm_t                           norm,
	output logic                                     norm_done
);

	logic [dnc_pkg::MANT_W-1:0] mag_abs;
	dnc_pkg::norm_t norm_q;

	assign mag_abs = mantissa[dnc_pkg::MANT_W-1] ? (~mantissa + 64'd1) : mantissa;
	assign norm_done = norm_q.zero || (norm_q.mag >= dnc_pkg::NORM_FLOOR);
	assign norm = norm_q;

	always_ff @(posedge clk) begin
		if (load) begin
			norm_q.neg  <= mantissa[dnc_pkg::MANT_W-1] && (mag_abs != '0);
			norm_q.zero <= (mag_abs == '0);
			norm_q.mag  <= mag_abs;
			norm_q.exp  <= {exponent[dnc_pkg::EXP_IN_W-1], exponent};
		end else if (!norm_done) begin
			// advance: times ten as shift-add
			norm_q.mag <= (norm_q.mag << 3) + (norm_q.mag << 1);
			norm_q.exp <= norm_q.exp - 33'sd1;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/dnc_merge.sv =====
// Merge stage: orders two normalized operands and registers the flags.
// Depends on dnc_pkg.
`default_nettype none
module dnc_merge (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           go,
	input  wire dnc_pkg::norm_t na,
	input  wire dnc_pkg::norm_t nb,
	output logic                done,
	output dnc_pkg::out_t       result
);

	logic eq;
	logic lt;
	logic done_q;
	dnc_pkg::out_t result_q;

	always_comb begin
		if (na.zero || nb.zero) begin
			eq = na.zero && nb.zero;
		end else begin
			eq = (na.neg == nb.neg) && (na.mag == nb.mag) && (na.exp == nb.exp);
		end
		if (na.neg != nb.neg) begin
			lt = na.neg;
		end else if (na.zero || nb.zero) begin
			lt = na.zero && !nb.zero;
		end else if (na.exp != nb.exp) begin
			lt = ($signed(na.exp) < $signed(nb.exp)) ^ na.neg;
		end else if (na.mag != nb.mag) begin
			lt = (na.mag < nb.mag) ^ na.neg;
		end else begin
			lt = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= go;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			result_q.is_equal <= eq;
			result_q.is_less  <= lt;
		end
	end

	assign done = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

// ===== hw/rtl/decimal_normalize_compare.sv =====
// Decimal normalize-and-compare top level: two normalizing lanes and a merge stage.
// Each lane's shift-add loop takes 0..18 multiply-by-ten steps; once both lanes
// are normalized, the merge stage registers the flags and raises the done beat.
// One beat in flight at a time; busy stays high until the merge stage fires.
// Reset clears the control state and the done strobe; the receiver cannot stall.
// Depends on dnc_pkg, dnc_lane and dnc_merge.
`default_nettype none
module decimal_normalize_compare (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	output logic              busy,
	input  wire dnc_pkg::in_t data,
	output logic              done,
	output dnc_pkg::out_t     result
);

	dnc_pkg::state_t state_q;
	dnc_pkg::state_t state_nxt;
	dnc_pkg::norm_t  norm_a;
	dnc_pkg::norm_t  norm_b;
	logic            done_a;
	logic            done_b;
	logic            load;
	logic            merge_go;

	assign load = start && !busy;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			dnc_pkg::ST_IDLE: begin
				if (start) state_nxt = dnc_pkg::ST_SCALE;
			end
			dnc_pkg::ST_SCALE: begin
				if (done_a && done_b) state_nxt = dnc_pkg::ST_IDLE;
			end
			default: state_nxt = dnc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy = 1'b0;
		merge_go = 1'b0;
		case (state_q)
			dnc_pkg::ST_IDLE: begin
				busy = 1'b0;
			end
			dnc_pkg::ST_SCALE: begin
				busy = 1'b1;
				merge_go = done_a && done_b;
			end
			default: begin
				busy = 1'b0;
				merge_go = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dnc_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	dnc_lane u_lane_a (
		.clk       (clk),
		.load      (load),
		.mantissa  (data.a_mantissa),
		.exponent  (data.a_exponent),
		.norm      (norm_a),
		.norm_done (done_a)
	);

	dnc_lane u_lane_b (
		.clk       (clk),
		.load      (load),
		.mantissa  (data.b_mantissa),
		.exponent  (data.b_exponent),
		.norm      (norm_b),
		.norm_done (done_b)
	);

	dnc_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (merge_go),
		.na     (norm_a),
		.nb     (norm_b),
		.done   (done),
		.result (result)
	);

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not raise busy");
	a_done_after_scale: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == dnc_pkg::ST_SCALE))
		else $error("done beat without a scaling phase");
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.is_equal && result.is_less))
		else $error("equal and less both set");
	a_single_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for two cycles");
`endif

endmodule
`default_nettype wire
